/* src/rdt_pkg.sv */
// Shared types, constants and the run-length table for the rolling digit transition.
package rdt_pkg;

    localparam int unsigned DIGIT_MAX         = 8;
    localparam int unsigned DIGIT_COUNT_DEF   = 8;
    localparam int unsigned HOLD_TICKS_DEF    = 25;
    localparam int unsigned CODE_W            = 4;
    localparam int unsigned PICK_W            = 6;
    localparam int unsigned RUN_W             = 7;
    localparam int unsigned HOLD_W            = 5;
    localparam int unsigned TABLE_DEPTH       = 64;

    localparam logic [CODE_W-1:0]            BLANK_CODE = 4'hC;
    localparam logic [CODE_W*DIGIT_MAX-1:0]  ALL_BLANK  = 32'hCCCC_CCCC;

    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_START = 1'b1;

    localparam logic [RUN_W-1:0] RUN_TABLE [0:TABLE_DEPTH-1] = '{
        7'd20, 7'd30, 7'd40, 7'd50, 7'd50, 7'd60, 7'd60, 7'd70,
        7'd15, 7'd25, 7'd35, 7'd45, 7'd55, 7'd55, 7'd55, 7'd65,
        7'd18, 7'd19, 7'd22, 7'd23, 7'd24, 7'd26, 7'd27, 7'd28,
        7'd29, 7'd31, 7'd32, 7'd33, 7'd34, 7'd36, 7'd37, 7'd38,
        7'd39, 7'd41, 7'd42, 7'd43, 7'd44, 7'd46, 7'd47, 7'd48,
        7'd49, 7'd16, 7'd51, 7'd17, 7'd52, 7'd68, 7'd53, 7'd67,
        7'd21, 7'd69, 7'd54, 7'd56, 7'd56, 7'd64, 7'd57, 7'd57,
        7'd66, 7'd58, 7'd58, 7'd63, 7'd59, 7'd59, 7'd61, 7'd62
    };

    typedef struct packed {
        logic                            func;
        logic [CODE_W*DIGIT_MAX-1:0]     digits;
        logic [PICK_W*DIGIT_MAX-1:0]     run_picks;
    } t_in_item;

    typedef struct packed {
        logic [CODE_W*DIGIT_MAX-1:0]     shown_digits;
        logic                            done_res;
    } t_out_item;

endpackage

/* src/rdt_lane.sv */
// One digit lane: its run counter and the next code it shows on a tick.
module rdt_lane (
    input  logic                              i_clk,
    input  logic                              i_load,
    input  logic                              i_step,
    input  logic [rdt_pkg::PICK_W-1:0]        i_pick,
    input  logic [rdt_pkg::CODE_W-1:0]        i_cur,
    input  logic [rdt_pkg::CODE_W-1:0]        i_target,
    output logic [rdt_pkg::CODE_W-1:0]        o_next,
    output logic                              o_settled
);

    logic [rdt_pkg::RUN_W-1:0]  r_runs;
    logic [rdt_pkg::RUN_W-1:0]  n_runs;
    logic [rdt_pkg::CODE_W:0]   w_inc;
    logic                       w_active;

    assign w_active  = (r_runs > rdt_pkg::RUN_W'(1));
    assign o_settled = ~w_active;
    assign w_inc     = {1'b0, i_cur} + (rdt_pkg::CODE_W+1)'(1);

    always_comb begin
        if (!w_active) begin
            o_next = i_target;
        end else if (i_cur == rdt_pkg::BLANK_CODE) begin
            o_next = '0;
        end else if (w_inc >= (rdt_pkg::CODE_W+1)'(10)) begin
            // The incremented code never reaches twenty, so one subtraction wraps it.
            o_next = rdt_pkg::CODE_W'(w_inc - (rdt_pkg::CODE_W+1)'(10));
        end else begin
            o_next = w_inc[rdt_pkg::CODE_W-1:0];
        end
    end

    always_comb begin
        n_runs = r_runs;
        if (i_load) begin
            n_runs = rdt_pkg::RUN_TABLE[i_pick];
        end else if (i_step && w_active) begin
            n_runs = r_runs - rdt_pkg::RUN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_runs <= n_runs;
    end

endmodule

/* src/rolling_digit_transition.sv */
// Rolling digit transition: one result per item, registered the cycle after its transfer.
// A new item can be taken in every cycle; input stall is raised only while the result
// register holds an untaken result and the output side stalls.
// Reset blanks every digit, clears the hold counter and stops the effect; run counters
// are not reset, as they are only read after a start has loaded them.
module rolling_digit_transition #(
    parameter int unsigned DIGIT_COUNT = rdt_pkg::DIGIT_COUNT_DEF,
    parameter int unsigned HOLD_TICKS  = rdt_pkg::HOLD_TICKS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  rdt_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output rdt_pkg::t_out_item  o_out_data
);

    localparam int unsigned WORD_W = rdt_pkg::CODE_W * rdt_pkg::DIGIT_MAX;
    localparam logic [rdt_pkg::HOLD_W-1:0] HoldInit = rdt_pkg::HOLD_W'(HOLD_TICKS);

    logic [WORD_W-1:0]           r_shown;
    logic [WORD_W-1:0]           n_shown;
    logic [rdt_pkg::HOLD_W-1:0]  r_hold;
    logic [rdt_pkg::HOLD_W-1:0]  n_hold;
    logic                        r_running;
    logic                        n_running;
    logic                        r_out_valid;
    logic                        n_out_valid;
    rdt_pkg::t_out_item          r_out;
    rdt_pkg::t_out_item          n_out;

    logic                        w_accept;
    logic                        w_start;
    logic                        w_step;
    logic [WORD_W-1:0]           w_tick_shown;
    logic [rdt_pkg::DIGIT_MAX-1:0] w_settled;
    logic                        w_all_settled;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_start     = w_accept && (i_in_data.func == rdt_pkg::FUNC_START);
    assign w_step      = w_accept && (i_in_data.func == rdt_pkg::FUNC_TICK) && r_running;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    for (genvar g = 0; g < rdt_pkg::DIGIT_MAX; g++) begin : g_lane
        if (g < DIGIT_COUNT) begin : g_active
            rdt_lane u_lane (
                .i_clk     (i_clk),
                .i_load    (w_start),
                .i_step    (w_step),
                .i_pick    (i_in_data.run_picks[rdt_pkg::PICK_W*g +: rdt_pkg::PICK_W]),
                .i_cur     (r_shown[rdt_pkg::CODE_W*g +: rdt_pkg::CODE_W]),
                .i_target  (i_in_data.digits[rdt_pkg::CODE_W*g +: rdt_pkg::CODE_W]),
                .o_next    (w_tick_shown[rdt_pkg::CODE_W*g +: rdt_pkg::CODE_W]),
                .o_settled (w_settled[g])
            );
        end else begin : g_fixed
            // Digits beyond the configured count keep what the start loaded.
            assign w_tick_shown[rdt_pkg::CODE_W*g +: rdt_pkg::CODE_W] =
                r_shown[rdt_pkg::CODE_W*g +: rdt_pkg::CODE_W];
            assign w_settled[g] = 1'b1;
        end
    end

    assign w_all_settled = &w_settled;

    always_comb begin
        n_shown     = r_shown;
        n_hold      = r_hold;
        n_running   = r_running;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        if (w_accept) begin
            n_out_valid = 1'b1;
            if (w_start) begin
                n_shown   = i_in_data.digits;
                n_hold    = HoldInit;
                n_running = 1'b1;
                n_out.shown_digits = i_in_data.digits;
                n_out.done_res     = 1'b0;
            end else if (!r_running) begin
                n_out.shown_digits = r_shown;
                n_out.done_res     = 1'b1;
            end else begin
                n_shown = w_tick_shown;
                if (w_all_settled && (r_hold != '0)) begin
                    n_hold = r_hold - rdt_pkg::HOLD_W'(1);
                end
                n_out.shown_digits = w_tick_shown;
                n_out.done_res     = w_all_settled && (n_hold == '0);
                n_running          = !(w_all_settled && (n_hold == '0));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shown     <= rdt_pkg::ALL_BLANK;
            r_hold      <= '0;
            r_running   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_shown     <= n_shown;
            r_hold      <= n_hold;
            r_running   <= n_running;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the rolling digit transition, with random traffic and a predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned N_DIGITS    = rdt_pkg::DIGIT_COUNT_DEF;
    localparam int unsigned HOLD_LEN    = rdt_pkg::HOLD_TICKS_DEF;
    localparam int          PHASE_ITEMS = 470;
    localparam int          LONG_HOLD   = 200;
    localparam int          END_WAIT    = 8;
    localparam int          CYCLE_LIMIT = 400000;

    logic               i_clk;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    rdt_pkg::t_in_item  i_in_data   = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    rdt_pkg::t_out_item o_out_data;

    rolling_digit_transition #(
        .DIGIT_COUNT (N_DIGITS),
        .HOLD_TICKS  (HOLD_LEN)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Predicted display state.
    logic [rdt_pkg::CODE_W*rdt_pkg::DIGIT_MAX-1:0] disp_shown   = rdt_pkg::ALL_BLANK;
    logic [rdt_pkg::RUN_W-1:0]                     disp_runs [rdt_pkg::DIGIT_MAX];
    logic [rdt_pkg::HOLD_W-1:0]                    disp_hold    = '0;
    logic                                          disp_running = 1'b0;

    rdt_pkg::t_in_item  pending_items[$];
    rdt_pkg::t_out_item expected_displays[$];

    int errors          = 0;
    int cycle_count     = 0;
    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int holds_requested = 0;
    int holds_started   = 0;
    int hold_left       = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic rdt_pkg::t_in_item make_item(logic f, logic [31:0] d, logic [47:0] p);
        rdt_pkg::t_in_item it;
        it.func      = f;
        it.digits    = d;
        it.run_picks = p;
        return it;
    endfunction

    // Applies one transfer to the predicted state and returns the display it should produce.
    function automatic rdt_pkg::t_out_item advance_display(rdt_pkg::t_in_item it);
        rdt_pkg::t_out_item                            res;
        logic [rdt_pkg::CODE_W*rdt_pkg::DIGIT_MAX-1:0] nxt;
        logic [rdt_pkg::CODE_W-1:0]                    cd;
        logic                                          settled;
        logic                                          done;
        if (it.func == rdt_pkg::FUNC_START) begin
            disp_shown = it.digits;
            for (int i = 0; i < rdt_pkg::DIGIT_MAX; i++) begin
                disp_runs[i] =
                    rdt_pkg::RUN_TABLE[it.run_picks[rdt_pkg::PICK_W*i +: rdt_pkg::PICK_W]];
            end
            disp_hold    = rdt_pkg::HOLD_W'(HOLD_LEN);
            disp_running = 1'b1;
            done         = 1'b0;
        end else if (!disp_running) begin
            done = 1'b1;
        end else begin
            settled = 1'b1;
            nxt     = disp_shown;
            for (int i = 0; i < N_DIGITS && i < rdt_pkg::DIGIT_MAX; i++) begin
                cd = disp_shown[rdt_pkg::CODE_W*i +: rdt_pkg::CODE_W];
                if (disp_runs[i] > 1) begin
                    disp_runs[i] = disp_runs[i] - 1'b1;
                    settled      = 1'b0;
                    nxt[rdt_pkg::CODE_W*i +: rdt_pkg::CODE_W] =
                        (cd == rdt_pkg::BLANK_CODE) ? '0 :
                        rdt_pkg::CODE_W'((int'(cd) + 1) % 10);
                end else begin
                    nxt[rdt_pkg::CODE_W*i +: rdt_pkg::CODE_W] =
                        it.digits[rdt_pkg::CODE_W*i +: rdt_pkg::CODE_W];
                end
            end
            disp_shown = nxt;
            if (settled && disp_hold != 0) begin
                disp_hold = disp_hold - 1'b1;
            end
            done = settled && (disp_hold == 0);
            if (done) begin
                disp_running = 1'b0;
            end
        end
        res.shown_digits = disp_shown;
        res.done_res     = done;
        return res;
    endfunction

    // A start followed by ticks; a complete effect runs through the hold until done.
    task automatic queue_effect(input bit complete, output int n);
        logic [47:0] picks;
        logic [31:0] target;
        int          longest;
        int          ticks;
        bit          fixed_target;
        picks   = 48'({$urandom, $urandom});
        longest = 1;
        for (int i = 0; i < N_DIGITS; i++) begin
            if (int'(rdt_pkg::RUN_TABLE[picks[rdt_pkg::PICK_W*i +: rdt_pkg::PICK_W]]) >
                    longest) begin
                longest = int'(rdt_pkg::RUN_TABLE[picks[rdt_pkg::PICK_W*i +: rdt_pkg::PICK_W]]);
            end
        end
        if (complete) begin
            ticks = longest - 1 + HOLD_LEN + $urandom_range(0, 3);
        end else begin
            ticks = $urandom_range(0, longest + HOLD_LEN - 2);
        end
        fixed_target = 1'($urandom_range(0, 1));
        target       = $urandom;
        pending_items.push_back(make_item(rdt_pkg::FUNC_START, $urandom, picks));
        for (int k = 0; k < ticks; k++) begin
            if (!fixed_target) begin
                target = $urandom;
            end
            pending_items.push_back(make_item(rdt_pkg::FUNC_TICK, target,
                                              48'({$urandom, $urandom})));
        end
        n = ticks + 1;
    endtask

    task automatic queue_phase(int n_items);
        int queued;
        int n;
        int r;
        queued = 0;
        while (queued < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
                queue_effect(1'b1, n);
            end else if (r < 92) begin
                queue_effect(1'b0, n);
            end else begin
                n = $urandom_range(1, 6);
                for (int k = 0; k < n; k++) begin
                    pending_items.push_back(make_item(1'($urandom_range(0, 1)), $urandom,
                                                      48'({$urandom, $urandom})));
                end
            end
            queued += n;
        end
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || i_in_valid || expected_displays.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Sender: offers queued items, holding each one until its transfer completes.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_displays.push_back(advance_display(i_in_data));
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= pending_items.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall, with the occasional long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   = hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (holds_started != holds_requested) begin
            holds_started = holds_started + 1;
            hold_left     = LONG_HOLD;
            i_out_stall   <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Checks every result transfer against the oldest expectation.
    always @(posedge i_clk) begin
        rdt_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_displays.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual %h/%b",
                         $realtime, o_out_data.shown_digits, o_out_data.done_res);
                errors++;
            end else begin
                want = expected_displays.pop_front();
                if (o_out_data.shown_digits !== want.shown_digits) begin
                    $display("%0t: shown_digits mismatch: expected %h, actual %h",
                             $realtime, want.shown_digits, o_out_data.shown_digits);
                    errors++;
                end
                if (o_out_data.done_res !== want.done_res) begin
                    $display("%0t: done_res mismatch: expected %b, actual %b",
                             $realtime, want.done_res, o_out_data.done_res);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding",
                     $realtime, expected_displays.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int send_idle_by_phase  [4] = '{0, 51, 0, 16};
        int recv_stall_by_phase [4] = '{0, 0, 51, 16};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Ticks while idle, a start with every lane on the last run table entry, restarts while running,
        // and start codes covering every non-decimal value.
        pending_items.push_back(make_item(rdt_pkg::FUNC_TICK,  32'h0000_0000, '1));
        pending_items.push_back(make_item(rdt_pkg::FUNC_TICK,  32'hFFFF_FFFF, '0));
        pending_items.push_back(make_item(rdt_pkg::FUNC_START, 32'hFFFF_FFFF, '1));
        pending_items.push_back(make_item(rdt_pkg::FUNC_TICK,  32'h0000_0000, '0));
        pending_items.push_back(make_item(rdt_pkg::FUNC_TICK,  32'h0000_0000, '1));
        pending_items.push_back(make_item(rdt_pkg::FUNC_START, rdt_pkg::ALL_BLANK, '0));
        pending_items.push_back(make_item(rdt_pkg::FUNC_TICK,  32'h1234_5678, '0));
        pending_items.push_back(make_item(rdt_pkg::FUNC_START, 32'hFEDC_BA98,
            {6'd45, 6'd7, 6'd41, 6'd43, 6'd8, 6'd63, 6'd0, 6'd49}));
        pending_items.push_back(make_item(rdt_pkg::FUNC_TICK,  32'hFFFF_FFFF, '0));
        pending_items.push_back(make_item(rdt_pkg::FUNC_TICK,  32'h0000_0000, '0));
        pending_items.push_back(make_item(rdt_pkg::FUNC_START, 32'h0000_0000, '0));
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = send_idle_by_phase[ph];
            recv_stall_pct = recv_stall_by_phase[ph];
            queue_phase(PHASE_ITEMS);
            if (ph == 0) begin
                // A long receiver hold while the sender keeps offering, so the block backs up.
                holds_requested++;
            end
            wait_drained();
        end

        repeat (END_WAIT) @(negedge i_clk);
        errors += expected_displays.size();
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
